// ===== hw/rtl/ilc_pkg.sv =====
// ilc_pkg: shared types and character constants of the ini line classifier
// used by every module of the block, no dependencies
package ilc_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       ends_line;
  } ilc_in_t;

  typedef struct packed {
    logic [2:0] line_class;
    logic       comment_open;
  } ilc_out_t;

  // one queue entry: up to two kept characters and an optional line end
  typedef struct packed {
    logic       ch0_vld;
    logic [7:0] ch0;
    logic       ch1_vld;
    logic [7:0] ch1;
    logic       eol;
    logic       comment_open;
  } ilc_evt_t;

  typedef struct packed {
    logic            text;
    logic            section;
    logic [1:0]      token_mode;
    logic [2:0]      token_count;
    logic [2:0][1:0] token_kinds;
    logic [1:0]      nonspace_count;
    logic            last_bracket;
  } ilc_line_t;

  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChLBrack  = 8'h5B;
  localparam logic [7:0] ChRBrack  = 8'h5D;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowZ    = 8'h7A;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpZ     = 8'h5A;

  localparam logic [1:0] ModeNone   = 2'd0;
  localparam logic [1:0] ModeId     = 2'd1;
  localparam logic [1:0] ModeString = 2'd2;
  localparam logic [1:0] ModeNumber = 2'd3;

  localparam logic [1:0] KindId     = 2'd0;
  localparam logic [1:0] KindEquals = 2'd1;
  localparam logic [1:0] KindNumber = 2'd2;
  localparam logic [1:0] KindString = 2'd3;

  localparam logic [2:0] ClsEmpty   = 3'd0;
  localparam logic [2:0] ClsNumber  = 3'd1;
  localparam logic [2:0] ClsString  = 3'd2;
  localparam logic [2:0] ClsSection = 3'd3;
  localparam logic [2:0] ClsIdId    = 3'd4;
  localparam logic [2:0] ClsInvalid = 3'd5;

endpackage

// ===== hw/rtl/ilc_fifo.sv =====
// ilc_fifo: small valid/ready queue between the front and back parts
// depends on ilc_pkg for the entry type
module ilc_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ilc_pkg::ilc_evt_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ilc_pkg::ilc_evt_t out_data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ilc_pkg::ilc_evt_t mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign in_ready_o  = (count_q != CntW'(Depth));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// ===== hw/rtl/ilc_front.sv =====
// ilc_front: accepts text bytes and strips comments with a two byte window
// depends on ilc_pkg; feeds kept characters and line ends into the queue
module ilc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ilc_pkg::ilc_in_t  in_data_i,
  output logic              evt_valid_o,
  input  logic              evt_ready_i,
  output ilc_pkg::ilc_evt_t evt_o
);

  logic       bco_q, bco_d;
  logic       cut_q, cut_d;
  logic       found_q, found_d;
  logic [1:0] hc_q, hc_d;
  logic [7:0] h0_q, h0_d;
  logic [7:0] h1_q, h1_d;
  logic       accept;
  logic [7:0] c;
  logic [7:0] h_last;
  ilc_pkg::ilc_evt_t evt;

  assign in_ready_o  = evt_ready_i;
  assign accept      = in_valid_i & in_ready_o;
  assign c           = in_data_i.char_code;
  assign h_last      = (hc_q == 2'd2) ? h1_q : h0_q;
  assign evt_o       = evt;
  assign evt_valid_o = accept & (evt.eol | evt.ch0_vld);

  always_comb begin
    bco_d   = bco_q;
    cut_d   = cut_q;
    found_d = found_q;
    hc_d    = hc_q;
    h0_d    = h0_q;
    h1_d    = h1_q;
    evt     = '0;
    if (in_data_i.ends_line) begin
      evt.eol          = 1'b1;
      evt.comment_open = bco_q;
      if (!bco_q && !cut_q) begin
        if (hc_q == 2'd2) begin
          if (!(h0_q == ilc_pkg::ChSlash && h1_q == ilc_pkg::ChSlash)) begin
            evt.ch0_vld = 1'b1;
            evt.ch0     = h0_q;
            evt.ch1_vld = 1'b1;
            evt.ch1     = h1_q;
          end
        end else if (hc_q == 2'd1) begin
          evt.ch0_vld = 1'b1;
          evt.ch0     = h0_q;
        end
      end
      hc_d    = 2'd0;
      cut_d   = 1'b0;
      found_d = 1'b0;
    end else if (found_q) begin
      hc_d = hc_q;
    end else if (bco_q) begin
      if (hc_q != 2'd0 && h0_q == ilc_pkg::ChStar && c == ilc_pkg::ChSlash) begin
        bco_d = 1'b0;
        hc_d  = 2'd0;
      end else begin
        h0_d = c;
        hc_d = 2'd1;
      end
    end else if (hc_q != 2'd0 && h_last == ilc_pkg::ChSlash && c == ilc_pkg::ChStar) begin
      if (hc_q == 2'd2 && !cut_q) begin
        evt.ch0_vld = 1'b1;
        evt.ch0     = h0_q;
      end
      cut_d   = 1'b1;
      found_d = 1'b1;
      bco_d   = 1'b1;
      hc_d    = 2'd0;
    end else if (hc_q == 2'd2) begin
      if (h0_q == ilc_pkg::ChSlash && h1_q == ilc_pkg::ChSlash) begin
        cut_d = 1'b1;
      end else if (!cut_q) begin
        evt.ch0_vld = 1'b1;
        evt.ch0     = h0_q;
      end
      h0_d = h1_q;
      h1_d = c;
    end else if (hc_q == 2'd1) begin
      h1_d = c;
      hc_d = 2'd2;
    end else begin
      h0_d = c;
      hc_d = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bco_q   <= 1'b0;
      cut_q   <= 1'b0;
      found_q <= 1'b0;
      hc_q    <= 2'd0;
    end else if (accept) begin
      bco_q   <= bco_d;
      cut_q   <= cut_d;
      found_q <= found_d;
      hc_q    <= hc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      h0_q <= h0_d;
      h1_q <= h1_d;
    end
  end

endmodule

// ===== hw/rtl/ilc_back.sv =====
// ilc_back: tokenizes kept characters and classifies each closed line
// depends on ilc_pkg; takes queue entries and drives the result register
module ilc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              evt_valid_i,
  output logic              evt_ready_o,
  input  ilc_pkg::ilc_evt_t evt_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ilc_pkg::ilc_out_t out_data_o
);

  function automatic logic is_letter(logic [7:0] c);
    return (c >= ilc_pkg::ChLowA && c <= ilc_pkg::ChLowZ) ||
           (c >= ilc_pkg::ChUpA && c <= ilc_pkg::ChUpZ);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= ilc_pkg::ChZero && c <= ilc_pkg::ChNine;
  endfunction

  function automatic ilc_pkg::ilc_line_t push_token(ilc_pkg::ilc_line_t s, logic [1:0] kind);
    ilc_pkg::ilc_line_t r;
    r = s;
    if (s.token_count < 3'd3) begin
      r.token_kinds[s.token_count[1:0]] = kind;
    end
    if (s.token_count < 3'd4) begin
      r.token_count = s.token_count + 3'd1;
    end
    return r;
  endfunction

  function automatic ilc_pkg::ilc_line_t token_feed(ilc_pkg::ilc_line_t s, logic [7:0] c);
    ilc_pkg::ilc_line_t r;
    logic               done;
    r    = s;
    done = 1'b0;
    if (s.token_mode == ilc_pkg::ModeId) begin
      if (is_letter(c) || is_digit(c)) begin
        done = 1'b1;
      end else begin
        r            = push_token(r, ilc_pkg::KindId);
        r.token_mode = ilc_pkg::ModeNone;
      end
    end else if (s.token_mode == ilc_pkg::ModeNumber) begin
      if (is_digit(c) || c == ilc_pkg::ChDot) begin
        done = 1'b1;
      end else begin
        r            = push_token(r, ilc_pkg::KindNumber);
        r.token_mode = ilc_pkg::ModeNone;
      end
    end else if (s.token_mode == ilc_pkg::ModeString) begin
      if (c == ilc_pkg::ChQuote) begin
        r            = push_token(r, ilc_pkg::KindString);
        r.token_mode = ilc_pkg::ModeNone;
      end
      done = 1'b1;
    end
    if (!done) begin
      if (c == ilc_pkg::ChEquals) begin
        r = push_token(r, ilc_pkg::KindEquals);
      end else if (is_letter(c)) begin
        r.token_mode = ilc_pkg::ModeId;
      end else if (c == ilc_pkg::ChQuote) begin
        r.token_mode = ilc_pkg::ModeString;
      end else if (is_digit(c) || c == ilc_pkg::ChDot) begin
        r.token_mode = ilc_pkg::ModeNumber;
      end
    end
    return r;
  endfunction

  function automatic ilc_pkg::ilc_line_t content_feed(ilc_pkg::ilc_line_t s, logic [7:0] c);
    ilc_pkg::ilc_line_t r;
    r = s;
    if (!s.text) begin
      r.text    = 1'b1;
      r.section = (c == ilc_pkg::ChLBrack);
    end
    if (c != ilc_pkg::ChSpace) begin
      if (s.nonspace_count < 2'd3) begin
        r.nonspace_count = s.nonspace_count + 2'd1;
      end
      r.last_bracket = (c == ilc_pkg::ChRBrack);
    end
    return token_feed(r, c);
  endfunction

  function automatic logic [2:0] classify(ilc_pkg::ilc_line_t s);
    ilc_pkg::ilc_line_t t;
    logic [2:0]         cls;
    t = token_feed(s, ilc_pkg::ChSpace);
    if (!s.text) begin
      cls = ilc_pkg::ClsEmpty;
    end else if (s.section) begin
      cls = (s.nonspace_count == 2'd3 && s.last_bracket) ? ilc_pkg::ClsSection
                                                          : ilc_pkg::ClsInvalid;
    end else if (t.token_count != 3'd3 || t.token_kinds[0] != ilc_pkg::KindId ||
                 t.token_kinds[1] != ilc_pkg::KindEquals) begin
      cls = ilc_pkg::ClsInvalid;
    end else begin
      unique case (t.token_kinds[2])
        ilc_pkg::KindNumber: cls = ilc_pkg::ClsNumber;
        ilc_pkg::KindString: cls = ilc_pkg::ClsString;
        ilc_pkg::KindId:     cls = ilc_pkg::ClsIdId;
        default:             cls = ilc_pkg::ClsInvalid;
      endcase
    end
    return cls;
  endfunction

  ilc_pkg::ilc_line_t line_q, line_d;
  ilc_pkg::ilc_line_t s0, s1;
  ilc_pkg::ilc_out_t  out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               pop;

  assign evt_ready_o = !evt_i.eol | !out_valid_q | out_ready_i;
  assign pop         = evt_valid_i & evt_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    s0          = evt_i.ch0_vld ? content_feed(line_q, evt_i.ch0) : line_q;
    s1          = evt_i.ch1_vld ? content_feed(s0, evt_i.ch1) : s0;
    line_d      = line_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (pop) begin
      if (evt_i.eol) begin
        line_d             = '0;
        out_valid_d        = 1'b1;
        out_d.line_class   = classify(s1);
        out_d.comment_open = evt_i.comment_open;
      end else begin
        line_d = s1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== hw/rtl/ini_line_classifier_top.sv =====
// Ini line classifier: one text byte or line end is taken per transfer, a sustained
// rate of one item per cycle while the queue is not full. The front strips comments
// through a two byte window and writes kept characters into a queue of QueueDepth
// entries; the back tokenizes and, on a line end, classifies the line into a result
// register, so a line end passes through the queue and then the result register
// before its result is offered. A stalled result only holds up line ends; bytes keep
// flowing until the queue is full.
// depends on ilc_pkg, ilc_front, ilc_fifo, ilc_back
module ini_line_classifier_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ilc_pkg::ilc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ilc_pkg::ilc_out_t out_data_o
);

  logic              f_valid, f_ready;
  ilc_pkg::ilc_evt_t f_evt;
  logic              b_valid, b_ready;
  ilc_pkg::ilc_evt_t b_evt;

  ilc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .evt_valid_o (f_valid),
    .evt_ready_i (f_ready),
    .evt_o       (f_evt)
  );

  ilc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_evt),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (b_evt)
  );

  ilc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (b_valid),
    .evt_ready_o (b_ready),
    .evt_i       (b_evt),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/ilc_checker.sv =====
// ilc_checker: port level checks of the ini line classifier, bound to the top level
// depends on ilc_pkg
module ilc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ilc_pkg::ilc_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ilc_pkg::ilc_out_t out_data_o
);

  logic [7:0] pending_q;
  logic       eol_in, res_out;

  assign eol_in  = in_valid_i & in_ready_o & in_data_i.ends_line;
  assign res_out = out_valid_o & out_ready_i;

  // line ends taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (eol_in && !res_out) begin
      pending_q <= pending_q + 8'd1;
    end else if (res_out && !eol_in) begin
      pending_q <= pending_q - 8'd1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni ##1 !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 8'd0)
    else $error("result without a pending line end");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.line_class <= ilc_pkg::ClsInvalid)
    else $error("line class out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind ini_line_classifier_top ilc_checker u_ilc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
